### sv/job_deadline_slot_scheduler_macros.svh
// Assertion macros for the job deadline slot scheduler.
// Clocked on clk_i, disabled while rst_ni is low; no other dependencies.
`ifndef JOB_DEADLINE_SLOT_SCHEDULER_MACROS_SVH
`define JOB_DEADLINE_SLOT_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define JDSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JDSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/jdss_pkg.sv
// Shared types and constants of the job deadline slot scheduler.
// No dependencies; imported by the engine, the top level and the testbench.
package jdss_pkg;

  localparam int SLOTS_DEF  = 256;
  localparam int JOB_W      = 16;
  localparam int DEADLINE_W = 16;
  localparam int CNT_W      = 9;
  localparam int IN_TW      = 32;

  localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 9'd256;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_F_UP,
    ST_F_WALK,
    ST_F_CMP,
    ST_F_CWALK,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_JOIN_A,
    ST_JOIN_B,
    ST_EMIT
  } jdss_state_e;

  typedef struct packed {
    logic idle;
    logic clearing;
  } jdss_stat_t;

endpackage

### sv/jdss_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module jdss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/jdss_engine.sv
// Union-find engine: parent-link and free-slot memories with the find,
// path-compression and union sequencer. Uses jdss_pkg and jdss_ram.
module jdss_engine
  import jdss_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  logic [JOB_W-1:0]                 req_job_i,
  input  logic [$clog2(SLOTS+1)-1:0]       req_slot_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic                             res_accepted_o,
  output logic [$clog2(SLOTS+1)-1:0]       res_slot_o,
  output logic [JOB_W-1:0]                 res_job_o,
  output jdss_stat_t                       stat_o
);

  localparam int NODES = SLOTS + 1;
  localparam int NW    = $clog2(NODES);
  localparam int PW    = NW + 1;

  jdss_state_e state_q, state_d;

  logic [NW-1:0]     clr_idx_q, clr_idx_d;
  logic [JOB_W-1:0]  job_q, job_d;
  logic [NW-1:0]     start_q, start_d;
  logic [NW-1:0]     cur_q, cur_d;
  logic [NW-1:0]     root_q, root_d;
  logic [PW-1:0]     root_sz_q, root_sz_d;
  logic [NW-1:0]     below_q, below_d;
  logic [PW-1:0]     below_sz_q, below_sz_d;
  logic [NW-1:0]     free_q, free_d;
  logic              second_q, second_d;
  logic              acc_q, acc_d;

  logic              link_we;
  logic [NW-1:0]     link_waddr, link_raddr;
  logic [PW-1:0]     link_wdata, link_rdata;
  logic              free_we;
  logic [NW-1:0]     free_waddr, free_raddr;
  logic [NW-1:0]     free_wdata, free_rdata;

  logic              link_is_root;
  logic [NW-1:0]     link_next;
  logic [NW-1:0]     tgt;
  logic              up_small;
  logic [PW-1:0]     total_sz;
  jdss_state_e       find_done;

  jdss_ram #(.WIDTH(PW), .DEPTH(NODES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  jdss_ram #(.WIDTH(NW), .DEPTH(NODES)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_we),
    .waddr_i (free_waddr),
    .wdata_i (free_wdata),
    .raddr_i (free_raddr),
    .rdata_o (free_rdata)
  );

  // negative link marks a root; its magnitude is the set size
  assign link_is_root = link_rdata[PW-1];
  assign link_next    = link_rdata[NW-1:0];
  assign tgt          = second_q ? below_q : root_q;
  assign up_small     = $signed(root_sz_q) > $signed(below_sz_q);
  assign total_sz     = root_sz_q + below_sz_q;
  assign find_done    = !second_q ? ST_FREE_RD :
                        (below_q == root_q) ? ST_EMIT : ST_JOIN_A;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:    if (clr_idx_q == NW'(SLOTS)) state_d = ST_IDLE;
      ST_IDLE:     if (req_valid_i) state_d = ST_F_UP;
      ST_F_UP:     state_d = ST_F_WALK;
      ST_F_WALK:   if (link_is_root) state_d = ST_F_CMP;
      ST_F_CMP:    state_d = (cur_q == tgt) ? find_done : ST_F_CWALK;
      ST_F_CWALK:  if (link_next == tgt) state_d = find_done;
      ST_FREE_RD:  state_d = ST_FREE_CHK;
      ST_FREE_CHK: state_d = (free_rdata == '0) ? ST_EMIT : ST_F_UP;
      ST_JOIN_A:   state_d = ST_JOIN_B;
      ST_JOIN_B:   state_d = ST_EMIT;
      ST_EMIT:     if (res_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_CLEAR;
    endcase
  end

  // memory ports and handshakes
  always_comb begin
    link_we     = 1'b0;
    link_waddr  = cur_q;
    link_wdata  = PW'(tgt);
    link_raddr  = cur_q;
    free_we     = 1'b0;
    free_waddr  = root_q;
    free_wdata  = free_rdata;
    free_raddr  = root_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr_idx_q;
        link_wdata = '1;
        free_we    = 1'b1;
        free_waddr = clr_idx_q;
        free_wdata = clr_idx_q;
      end
      ST_IDLE:  req_ready_o = 1'b1;
      ST_F_UP:  link_raddr = cur_q;
      ST_F_WALK: link_raddr = link_next;
      ST_F_CMP: link_raddr = cur_q;
      ST_F_CWALK: begin
        // point this node straight at the root, fetch the next one
        link_we    = 1'b1;
        link_waddr = cur_q;
        link_wdata = PW'(tgt);
        link_raddr = link_next;
      end
      ST_FREE_RD: free_raddr = root_q;
      ST_FREE_CHK: free_raddr = root_q;
      ST_JOIN_A: begin
        link_we    = 1'b1;
        free_raddr = below_q;
        if (up_small) begin
          link_waddr = root_q;
          link_wdata = PW'(below_q);
        end else begin
          link_waddr = below_q;
          link_wdata = PW'(root_q);
        end
      end
      ST_JOIN_B: begin
        link_we    = 1'b1;
        link_wdata = total_sz;
        if (up_small) begin
          link_waddr = below_q;
        end else begin
          // upper root survives: it inherits the lower set's free slot
          link_waddr = root_q;
          free_we    = 1'b1;
          free_waddr = root_q;
          free_wdata = free_rdata;
        end
      end
      ST_EMIT:  res_valid_o = 1'b1;
      default:  req_ready_o = 1'b0;
    endcase
  end

  // datapath registers
  always_comb begin
    clr_idx_d  = clr_idx_q;
    job_d      = job_q;
    start_d    = start_q;
    cur_d      = cur_q;
    root_d     = root_q;
    root_sz_d  = root_sz_q;
    below_d    = below_q;
    below_sz_d = below_sz_q;
    free_d     = free_q;
    second_d   = second_q;
    acc_d      = acc_q;
    unique case (state_q)
      ST_CLEAR: clr_idx_d = clr_idx_q + 1'b1;
      ST_IDLE: begin
        if (req_valid_i) begin
          job_d    = req_job_i;
          start_d  = req_slot_i;
          cur_d    = req_slot_i;
          second_d = 1'b0;
        end
      end
      ST_F_WALK: begin
        if (link_is_root) begin
          if (second_q) begin
            below_d    = cur_q;
            below_sz_d = link_rdata;
          end else begin
            root_d     = cur_q;
            root_sz_d  = link_rdata;
          end
          cur_d = start_q;
        end else begin
          cur_d = link_next;
        end
      end
      ST_F_CWALK: cur_d = link_next;
      ST_FREE_CHK: begin
        free_d   = free_rdata;
        acc_d    = (free_rdata != '0);
        start_d  = free_rdata - 1'b1;
        cur_d    = free_rdata - 1'b1;
        second_d = 1'b1;
      end
      default: acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    start_q    <= start_d;
    cur_q      <= cur_d;
    root_q     <= root_d;
    root_sz_q  <= root_sz_d;
    below_q    <= below_d;
    below_sz_q <= below_sz_d;
    free_q     <= free_d;
    second_q   <= second_d;
    acc_q      <= acc_d;
  end

  assign res_accepted_o  = acc_q;
  assign res_slot_o      = free_q;
  assign res_job_o       = job_q;
  assign stat_o.idle     = (state_q == ST_IDLE);
  assign stat_o.clearing = (state_q == ST_CLEAR);

endmodule

### sv/job_deadline_slot_scheduler.sv
// Top level of the job deadline slot scheduler: slot-count register,
// deadline clamp, output register. Uses jdss_pkg, jdss_engine, macros header.
//
//   channel | direction | transfer carries
//   --------+-----------+-------------------------------------------------
//   cfg     | in        | slot_count (write enable, no handshake)
//   s_axis  | in        | job_id, deadline
//   m_axis  | out       | accepted, slot, job_echo
//
// Flow: one job at a time; a rejected job runs one find and a placed one two,
// the second followed by a union unless both finds end in the same set.
// Every link step is one read of the single-read-port parent-link memory,
// and path compression walks the path a second time.
// Reset: a clearing pass over slots 0..SLOTS rebuilds singleton sets; s_axis
// is held not ready meanwhile, configuration writes are taken at any time.
// Stalls: a finished result waits in the output register while the next job
// is taken; the engine holds only if that register is still full when done.
`include "job_deadline_slot_scheduler_macros.svh"

module job_deadline_slot_scheduler
  import jdss_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_wr_en_i,
  input  logic [CNT_W-1:0] cfg_wr_data_i,   // slot_count
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_TW-1:0] s_axis_tdata,    // [15:0] job_id, [31:16] deadline
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [0] accepted, [NW:1] slot, [NW+16:NW+1] job_echo, zero fill above
  output logic [((JOB_W + $clog2(SLOTS+1) + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int NW     = $clog2(SLOTS + 1);
  localparam int OUT_TW = ((JOB_W + NW + 1 + 7) / 8) * 8;
  localparam int CMP_W  = (NW > DEADLINE_W) ? NW : DEADLINE_W;

  logic [CNT_W-1:0]  slot_count_q, slot_count_d;
  logic              out_valid_q, out_valid_d;
  logic [OUT_TW-1:0] out_data_q, out_data_d;

  logic [CMP_W-1:0]  cnt_ext, lim, dl_ext, dl_clamped;
  logic [NW-1:0]     req_slot;
  logic              res_valid, res_ready, res_accepted;
  logic [NW-1:0]     res_slot;
  logic [JOB_W-1:0]  res_job;
  jdss_stat_t        eng_stat;

  // Latch the slot count on every write; the clamp reads it at acceptance.
  always_comb begin
    slot_count_d = slot_count_q;
    if (cfg_wr_en_i) begin
      slot_count_d = cfg_wr_data_i;
    end
  end

  // Clamp the slot count to 1..SLOTS, then the deadline to the slot count.
  always_comb begin
    cnt_ext = CMP_W'(slot_count_q);
    dl_ext  = CMP_W'(s_axis_tdata[JOB_W +: DEADLINE_W]);
    priority if (cnt_ext == '0) begin
      lim = CMP_W'(1);
    end else if (cnt_ext > CMP_W'(SLOTS)) begin
      lim = CMP_W'(SLOTS);
    end else begin
      lim = cnt_ext;
    end
    dl_clamped = (dl_ext > lim) ? lim : dl_ext;
  end

  assign req_slot = dl_clamped[NW-1:0];

  jdss_engine #(.SLOTS(SLOTS)) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_o    (s_axis_tready),
    .req_job_i      (s_axis_tdata[JOB_W-1:0]),
    .req_slot_i     (req_slot),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_accepted_o (res_accepted),
    .res_slot_o     (res_slot),
    .res_job_o      (res_job),
    .stat_o         (eng_stat)
  );

  // Output register: load when empty or draining in the same cycle.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = OUT_TW'({res_job, res_slot, res_accepted});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_COUNT_RST;
      out_valid_q  <= 1'b0;
    end else begin
      slot_count_q <= slot_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A placed job always holds a real slot; a rejected one holds slot zero.
  `JDSS_ASSERT_NOW(a_slot_matches_accept, m_axis_tvalid, m_axis_tdata[0] == (m_axis_tdata[NW:1] != '0), "slot and accepted flag disagree")
  // A taken job must put the engine to work.
  `JDSS_ASSERT_NEXT(a_take_starts_work, s_axis_tvalid && s_axis_tready, !eng_stat.idle, "engine idle after taking a job")
  // The clearing pass hands over to idle and nothing else.
  `JDSS_ASSERT_NOW(a_clear_ends_idle, $fell(eng_stat.clearing), eng_stat.idle, "clearing pass did not end in idle")
  // A finished result must land in the output register.
  `JDSS_ASSERT_NEXT(a_result_lands, res_valid && res_ready, m_axis_tvalid, "result lost on the way out")

endmodule

### sim/tb_top.sv
// Self-checking testbench for job_deadline_slot_scheduler.
// Keeps its own union-find slot model in a scoreboard class and checks every result transfer.
// Depends only on jdss_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb_top;
  import jdss_pkg::*;

  localparam int SLOTS      = SLOTS_DEF;
  localparam int NODES      = SLOTS + 1;
  localparam int SLOT_W     = $clog2(SLOTS + 1);
  localparam int OUT_TW     = ((JOB_W + SLOT_W + 1 + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 6000;  // cycles with no transfer on either side
  localparam int TAIL_CYCLES = 120;   // settle time after the last result
  localparam int PHASE_JOBS  = 190;

  // One predicted or observed result transfer.
  typedef struct packed {
    logic              placed;
    logic [SLOT_W-1:0] slot;
    logic [JOB_W-1:0]  job;
  } outcome_t;

  // Slot model: union-find over slots 0..SLOTS, slot 0 the closed sentinel.
  class job_slot_scoreboard;
    int       link [NODES];         // parent slot, or minus the set size at a root
    int       latest_free [NODES];  // latest free slot of a set, valid at roots
    int       slot_limit;
    outcome_t outcomes [$];
    int       mismatches;
    int       placed_cnt;
    int       turned_away;

    function new();
      for (int k = 0; k < NODES; k++) begin
        link[k] = -1;
        latest_free[k] = k;
      end
      slot_limit = SLOT_COUNT_RST;
      mismatches = 0;
      placed_cnt = 0;
      turned_away = 0;
    endfunction

    function void set_slot_limit(int value);
      slot_limit = value;
    endfunction

    function int pending();
      return outcomes.size();
    endfunction

    // Collapsing find: locate the root, then point the whole path at it.
    function int find_root(int x);
      int r;
      int nxt;
      r = x;
      while (link[r] >= 0) r = link[r];
      while (x != r) begin
        nxt = link[x];
        link[x] = r;
        x = nxt;
      end
      return r;
    endfunction

    // Predict the result of an accepted job and advance the slot sets.
    function void note_job(logic [JOB_W-1:0] job, logic [DEADLINE_W-1:0] deadline);
      int       n;
      int       d;
      int       r;
      int       f;
      int       below;
      int       total;
      outcome_t o;
      n = slot_limit;
      if (n < 1) n = 1;
      if (n > SLOTS) n = SLOTS;
      d = deadline;
      if (d > n) d = n;
      r = find_root(d);
      f = latest_free[r];
      o.job = job;
      if (f == 0) begin
        o.placed = 1'b0;
        o.slot = '0;
        turned_away++;
      end else begin
        below = find_root(f - 1);
        if (below != r) begin
          total = link[r] + link[below];
          if (link[r] > link[below]) begin
            // upper set is smaller: hang it below the lower root
            link[r] = below;
            link[below] = total;
          end else begin
            link[below] = r;
            link[r] = total;
            latest_free[r] = latest_free[below];
          end
        end
        o.placed = 1'b1;
        o.slot = SLOT_W'(f);
        placed_cnt++;
      end
      outcomes.push_back(o);
    endfunction

    function void flag(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void check_result(logic [OUT_TW-1:0] data);
      outcome_t got;
      outcome_t want;
      got.placed = data[0];
      got.slot   = data[SLOT_W:1];
      got.job    = data[SLOT_W+JOB_W:SLOT_W+1];
      if (outcomes.size() == 0) begin
        flag("unexpected result, job_echo", -1, got.job);
        return;
      end
      want = outcomes.pop_front();
      if (got.placed !== want.placed) flag("accepted", want.placed, got.placed);
      if (got.slot !== want.slot) flag("slot", want.slot, got.slot);
      if (got.job !== want.job) flag("job_echo", want.job, got.job);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_wr_en_i;
  logic [CNT_W-1:0]  cfg_wr_data_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_TW-1:0]  s_axis_tdata;    // [15:0] job_id, [31:16] deadline
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_TW-1:0] m_axis_tdata;    // [0] accepted, [9:1] slot, [25:10] job_echo

  job_slot_scoreboard sb;
  int settings_seen;
  int quiet_cycles;
  bit tx_calm;
  bit rx_calm;

  job_deadline_slot_scheduler #(.SLOTS(SLOTS)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Idle length: mostly short, now and then long, none at all in calm stretches.
  function automatic int pick_idle(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Deadline mix: mostly inside the active window, some zero, some far beyond it.
  function automatic logic [DEADLINE_W-1:0] pick_deadline(int limit);
    int n;
    int r;
    n = (limit < 1) ? 1 : (limit > SLOTS) ? SLOTS : limit;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 70) return DEADLINE_W'($urandom_range(1, n + 3));
    if (r < 82) return DEADLINE_W'(n - 1 + $urandom_range(0, 2));
    if (r < 85) return '1;
    return DEADLINE_W'($urandom);
  endfunction

  // Offer one job and hold it until the block takes it.
  task automatic send_job(logic [JOB_W-1:0] job, logic [DEADLINE_W-1:0] deadline);
    int gap;
    gap = pick_idle(tx_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {deadline, job};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_job(job, deadline);
  endtask

  // Drop valid and hold off until every predicted result has been seen.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  // Single-cycle register write; only issued with the block drained.
  task automatic write_slot_count(logic [CNT_W-1:0] value);
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    sb.set_slot_limit(value);
    settings_seen++;
  endtask

  // Result side: stall at random, then take one transfer and check it.
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      stall = pick_idle(rx_calm);
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [CNT_W-1:0] phase_limits [8];
    int               sent;

    sb = new();
    settings_seen = 1;  // reset value counts as the first setting
    quiet_cycles = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    sent = 0;

    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;

    // Hold reset, then release away from the rising edge.
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset slot count, zero deadline, deadlines at and past the top,
    // a filled slot 1 turning later jobs away, extreme ids.
    send_job(16'h0000, 16'h0000);
    send_job(16'hFFFF, 16'hFFFF);
    send_job(16'h0001, 16'd257);
    send_job(16'h0002, 16'd1);
    send_job(16'h0003, 16'd1);
    send_job(16'h0004, 16'd2);
    send_job(16'h0005, 16'd256);
    send_job(16'hAAAA, 16'h5555);
    send_job(16'h5555, 16'hAAAA);
    sent += 9;

    // A zero slot count behaves as one: deadlines clamp to 1 or 0, all turned away.
    drain();
    write_slot_count(9'd0);
    send_job(16'h0010, 16'd1);
    send_job(16'h0011, 16'hFFFF);
    send_job(16'h0012, 16'd0);

    // All ones is above the slot range and clamps to the full table.
    drain();
    write_slot_count(9'h1FF);
    send_job(16'h0020, 16'd300);
    send_job(16'h0021, 16'd3);
    send_job(16'h0022, 16'd3);
    send_job(16'h0023, 16'd256);
    sent += 7;

    // Random phases; the slot store carries over, so small windows come first.
    phase_limits[0] = 9'd20;
    phase_limits[1] = 9'd1;
    phase_limits[2] = 9'd64;
    phase_limits[3] = 9'd0;
    phase_limits[4] = 9'd160;
    phase_limits[5] = CNT_W'($urandom_range(0, 511));
    phase_limits[6] = 9'h1FF;
    phase_limits[7] = 9'd256;

    for (int p = 0; p < 8; p++) begin
      drain();
      write_slot_count(phase_limits[p]);
      for (int i = 0; i < PHASE_JOBS; i++) begin
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        // mid-phase hold-off: let the result side run dry once
        if (p == 2 && i == PHASE_JOBS / 2) drain();
        send_job(JOB_W'($urandom), pick_deadline(phase_limits[p]));
        sent++;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d jobs across %0d slot-count settings, zero and over-range included.",
             sent, settings_seen);
    $display("%0d jobs got a slot, %0d were turned away; %0d mismatches.",
             sb.placed_cnt, sb.turned_away, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/jdss_pkg.sv
sv/jdss_ram.sv
sv/jdss_engine.sv
sv/job_deadline_slot_scheduler.sv
sim/tb_top.sv
